FILE: rtl/rcwl_pkg.sv
// Package for the ring counter wear leveler.
// Holds field widths, word constants and transaction kind codes; no dependencies.
package rcwl_pkg;

   // Default number of words in the ring.
   localparam int RING_SIZE_DEFAULT = 128;

   // Field widths of the request and response transactions.
   localparam int KIND_W  = 2;
   localparam int COUNT_W = 31;
   localparam int WORD_W  = 32;
   localparam int SLOT_W  = 7;

   // Stored word patterns.
   localparam logic [WORD_W-1:0] ERASED_WORD = 32'hFFFF_FFFF;
   localparam logic [WORD_W-1:0] ZERO_WORD   = 32'h0000_0000;

   // Transaction kind codes.
   localparam logic [KIND_W-1:0] KIND_WRITE   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_CLEAR   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_RECOVER = 2'd2;

endpackage

FILE: rtl/rcwl_req_if.sv
// Request channel interface for the ring counter wear leveler.
// Depends on rcwl_pkg for the field widths.
interface rcwl_req_if import rcwl_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [KIND_W-1:0]  kind;
   logic [COUNT_W-1:0] new_count;
   logic               lock_flag;

   modport source (output valid, output kind, output new_count, output lock_flag,
                   input ready);
   modport sink   (input valid, input kind, input new_count, input lock_flag,
                   output ready);
endinterface

FILE: rtl/rcwl_rsp_if.sv
// Response channel interface for the ring counter wear leveler.
// Depends on rcwl_pkg for the field widths.
interface rcwl_rsp_if import rcwl_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [COUNT_W-1:0] current_count;
   logic               current_lock;
   logic [SLOT_W-1:0]  write_slot;
   logic               was_cleared;

   modport source (output valid, output current_count, output current_lock,
                   output write_slot, output was_cleared, input ready);
   modport sink   (input valid, input current_count, input current_lock,
                   input write_slot, input was_cleared, output ready);
endinterface

FILE: rtl/ring_counter_wear_leveler.sv
// Ring counter wear leveler: a ring of counter words in a RAM, walked by a sequencer.
// Depends on rcwl_pkg, rcwl_req_if, rcwl_rsp_if and rcwl_ram.
// A write or unknown kind goes straight to the result hand-off; a clear wipes the ring; a
// recover scans the ring, followed by a wipe when an erased word is found.
// Throughput: one transaction at a time; a fill, wipe or scan walks one word per cycle.
// Reset: a fill pass writes every word erased; no request is taken.
module ring_counter_wear_leveler import rcwl_pkg::*; #(
   parameter int RING_SIZE = RING_SIZE_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   rcwl_req_if.sink   req_ch,
   rcwl_rsp_if.source rsp_ch
);

   localparam int AW = $clog2(RING_SIZE);
   localparam logic [AW-1:0] LAST_SLOT = AW'(RING_SIZE - 1);

   typedef enum logic [4:0] {
      ST_INIT = 5'b00001,
      ST_IDLE = 5'b00010,
      ST_WIPE = 5'b00100,
      ST_SCAN = 5'b01000,
      ST_DONE = 5'b10000
   } state_type;

   state_type          state_ff, state_in;
   logic [AW-1:0]      idx_ff, idx_in;
   logic               issue_ff, issue_in;
   logic               dv_ff, dv_in;
   logic [AW-1:0]      didx_ff, didx_in;
   logic [AW-1:0]      ptr_ff, ptr_in;
   logic [WORD_W-1:0]  latest_ff, latest_in;
   logic               cleared_ff, cleared_in;

   // Scan accumulators.
   logic [COUNT_W-1:0] best_ff, best_in;
   logic               best_lock_ff, best_lock_in;
   logic [AW-1:0]      best_slot_ff, best_slot_in;
   logic [COUNT_W-1:0] prev_ff, prev_in;
   logic               erased_ff, erased_in;

   // Response register.
   logic               rsp_valid_ff, rsp_valid_in;
   logic [COUNT_W-1:0] rsp_count_ff, rsp_count_in;
   logic               rsp_lock_ff, rsp_lock_in;
   logic [SLOT_W-1:0]  rsp_slot_ff, rsp_slot_in;
   logic               rsp_clr_ff, rsp_clr_in;

   // RAM port signals.
   logic               ram_we;
   logic [AW-1:0]      ram_waddr;
   logic [WORD_W-1:0]  ram_wdata;
   logic               ram_re;
   logic [WORD_W-1:0]  ram_rdata;

   logic               req_take;
   logic [WORD_W-1:0]  req_word;
   logic [COUNT_W-1:0] cur_count;
   logic               cur_erased;
   logic               cur_step;
   logic [COUNT_W:0]   prev_plus;
   logic               rsp_free;

   rcwl_ram #(
      .WIDTH (WORD_W),
      .DEPTH (RING_SIZE)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (idx_ff),
      .rd_data (ram_rdata)
   );

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_take     = req_ch.valid && req_ch.ready;
   assign req_word     = {req_ch.lock_flag, req_ch.new_count};
   assign rsp_free     = !rsp_valid_ff || rsp_ch.ready;

   // Compare unit: one scanned word against the running state.
   assign cur_count  = ram_rdata[COUNT_W-1:0];
   assign cur_erased = (ram_rdata == ERASED_WORD);
   assign prev_plus  = {1'b0, prev_ff} + {{COUNT_W{1'b0}}, 1'b1};
   assign cur_step   = (cur_count > best_ff) && (prev_plus == {1'b0, cur_count});

   // Sequencer.
   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      issue_in     = 1'b0;
      dv_in        = 1'b0;
      didx_in      = idx_ff;
      ptr_in       = ptr_ff;
      latest_in    = latest_ff;
      cleared_in   = cleared_ff;
      best_in      = best_ff;
      best_lock_in = best_lock_ff;
      best_slot_in = best_slot_ff;
      prev_in      = prev_ff;
      erased_in    = erased_ff;
      ram_we       = 1'b0;
      ram_waddr    = idx_ff;
      ram_wdata    = ZERO_WORD;
      ram_re       = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_count_in = rsp_count_ff;
      rsp_lock_in  = rsp_lock_ff;
      rsp_slot_in  = rsp_slot_ff;
      rsp_clr_in   = rsp_clr_ff;

      case (state_ff)
         ST_INIT: begin
            // Fill every word with the erased pattern after reset.
            ram_we    = 1'b1;
            ram_wdata = ERASED_WORD;
            idx_in    = idx_ff + 1'b1;
            if (idx_ff == LAST_SLOT) begin
               idx_in   = '0;
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_take) begin
               cleared_in = 1'b0;
               idx_in     = '0;
               case (req_ch.kind)
                  KIND_WRITE: begin
                     ram_we    = 1'b1;
                     ram_waddr = ptr_ff;
                     ram_wdata = req_word;
                     ptr_in    = (ptr_ff == LAST_SLOT) ? '0 : ptr_ff + 1'b1;
                     latest_in = req_word;
                     state_in  = ST_DONE;
                  end
                  KIND_CLEAR: begin
                     state_in = ST_WIPE;
                  end
                  KIND_RECOVER: begin
                     issue_in = 1'b1;
                     state_in = ST_SCAN;
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_WIPE: begin
            // Zero every word, then reset the pointer and latest record.
            ram_we = 1'b1;
            idx_in = idx_ff + 1'b1;
            if (idx_ff == LAST_SLOT) begin
               idx_in     = '0;
               ptr_in     = '0;
               latest_in  = ZERO_WORD;
               cleared_in = 1'b1;
               state_in   = ST_DONE;
            end
         end
         ST_SCAN: begin
            // Issue one read per cycle; process each returned word in the cycle after its read.
            ram_re = issue_ff;
            dv_in  = issue_ff;
            if (issue_ff) begin
               idx_in   = idx_ff + 1'b1;
               issue_in = (idx_ff != LAST_SLOT);
            end
            if (dv_ff) begin
               prev_in = cur_count;
               if (didx_ff == '0) begin
                  best_in      = cur_count;
                  best_lock_in = ram_rdata[WORD_W-1];
                  best_slot_in = '0;
                  erased_in    = cur_erased;
               end else begin
                  erased_in = erased_ff || cur_erased;
                  if (cur_step) begin
                     best_in      = cur_count;
                     best_lock_in = ram_rdata[WORD_W-1];
                     best_slot_in = didx_ff;
                  end
               end
               if (didx_ff == LAST_SLOT) begin
                  idx_in = '0;
                  if (erased_in) begin
                     state_in = ST_WIPE;
                  end else begin
                     ptr_in    = (best_slot_in == LAST_SLOT) ? '0 : best_slot_in + 1'b1;
                     latest_in = {best_lock_in, best_in};
                     state_in  = ST_DONE;
                  end
               end
            end
         end
         ST_DONE: begin
            // Hand the result to the response register once it is free.
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_count_in = latest_ff[COUNT_W-1:0];
               rsp_lock_in  = latest_ff[WORD_W-1];
               rsp_slot_in  = SLOT_W'(ptr_ff);
               rsp_clr_in   = cleared_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         idx_ff       <= '0;
         issue_ff     <= 1'b0;
         dv_ff        <= 1'b0;
         ptr_ff       <= '0;
         latest_ff    <= ZERO_WORD;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         issue_ff     <= issue_in;
         dv_ff        <= dv_in;
         ptr_ff       <= ptr_in;
         latest_ff    <= latest_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload and scan registers.
   always_ff @(posedge clock) begin
      didx_ff      <= didx_in;
      cleared_ff   <= cleared_in;
      best_ff      <= best_in;
      best_lock_ff <= best_lock_in;
      best_slot_ff <= best_slot_in;
      prev_ff      <= prev_in;
      erased_ff    <= erased_in;
      rsp_count_ff <= rsp_count_in;
      rsp_lock_ff  <= rsp_lock_in;
      rsp_slot_ff  <= rsp_slot_in;
      rsp_clr_ff   <= rsp_clr_in;
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.current_count = rsp_count_ff;
   assign rsp_ch.current_lock  = rsp_lock_ff;
   assign rsp_ch.write_slot    = rsp_slot_ff;
   assign rsp_ch.was_cleared   = rsp_clr_ff;

`ifndef SYNTH
   // The RAM is never written while a scan is reading it.
   a_no_write_in_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> !ram_we)
      else $error("RAM written during recover scan");

   // A write transaction makes its word the latest record.
   a_write_latest: assert property (@(posedge clock) disable iff (reset)
      (req_take && req_ch.kind == KIND_WRITE) |=> (latest_ff == $past(req_word)))
      else $error("latest record does not follow write");

   // A new response only comes out of the result hand-off state.
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !$past(rsp_valid_ff && !rsp_ch.ready)) |-> $past(state_ff == ST_DONE))
      else $error("response raised outside hand-off");

   // The write pointer stays inside the ring.
   a_ptr_range: assert property (@(posedge clock) disable iff (reset)
      (32'(ptr_ff) < RING_SIZE))
      else $error("write pointer out of range");
`endif

endmodule

FILE: rtl/rcwl_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module rcwl_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
